### src/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types, codes and slot arithmetic for the record deque with key search.
// ----------------------------------------------------------------------------
package rdq_pkg;

    localparam int DEPTH  = 16;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = SLOT_W + 1;

    localparam int ID_W   = 32;
    localparam int NAME_W = 64;
    localparam int BAL_W  = 32;
    localparam int OP_W   = 3;
    localparam int ST_W   = 2;

    localparam logic [OP_W-1:0] OP_ADD_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd2;
    localparam logic [OP_W-1:0] OP_WALK_FWD  = 3'd3;
    localparam logic [OP_W-1:0] OP_WALK_BWD  = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND_ID   = 3'd5;
    localparam logic [OP_W-1:0] OP_FIND_NAME = 3'd6;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd3;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [NAME_W-1:0] name;
        logic [BAL_W-1:0]  balance;
    } record_t;

    typedef struct packed {
        logic    en;
        slot_t   addr;
        record_t data;
    } wr_req_t;

    typedef struct packed {
        logic  en;
        slot_t addr;
    } rd_req_t;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    function automatic slot_t slot_inc(input slot_t a);
        slot_t r;
        if (a == SLOT_W'(DEPTH - 1))
            r = '0;
        else
            r = a + SLOT_W'(1);
        return r;
    endfunction

    function automatic slot_t slot_dec(input slot_t a);
        slot_t r;
        if (a == '0)
            r = SLOT_W'(DEPTH - 1);
        else
            r = a - SLOT_W'(1);
        return r;
    endfunction

    // Both operands are below DEPTH, so one conditional subtract wraps the sum.
    function automatic slot_t slot_add(input slot_t a, input slot_t b);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= SUM_W'(DEPTH))
            sum = sum - SUM_W'(DEPTH);
        return sum[SLOT_W-1:0];
    endfunction

endpackage

### src/record_deque_with_key_search_unit.sv
// ----------------------------------------------------------------------------
// record_deque_with_key_search_unit
// Ring of account records with front/back insert, front removal, walks and
// first-match search by id or name.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is taken on a rising edge with start high and busy low.
// Every command produces its results on status/out_id/out_name/out_balance/last,
// each valid for exactly one cycle while result_valid is high; the receiver
// cannot stall, so results are never held. last marks the final result of a
// command. Op seven is taken and produces nothing.
// Adds and remove answer in the cycle after the transaction and keep busy low, so
// a new command may follow on the very next cycle.
// Walks and searches on a non-empty store read one record per cycle from the
// record memory; the first result passes the read data register and then the
// result register. A walk returns one result per record and a search stops at
// its first hit; busy falls as the final result appears.
// Reset empties the store at once; record memory content is not cleared and
// only slots that hold a record are ever read.
// ----------------------------------------------------------------------------
module record_deque_with_key_search_unit
    import rdq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   op,
    input  logic [ID_W-1:0]   in_id,
    input  logic [NAME_W-1:0] in_name,
    input  logic [BAL_W-1:0]  in_balance,
    output logic              result_valid,
    output logic [ST_W-1:0]   status,
    output logic [ID_W-1:0]   out_id,
    output logic [NAME_W-1:0] out_name,
    output logic [BAL_W-1:0]  out_balance,
    output logic              last
);

    state_t            state_reg, state_next;
    slot_t             front_reg, front_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    slot_t             scan_slot_reg, scan_slot_next;
    slot_t             scan_k_reg, scan_k_next;
    logic [OP_W-1:0]   scan_op_reg, scan_op_next;
    logic [ID_W-1:0]   key_id_reg, key_id_next;
    logic [NAME_W-1:0] key_name_reg, key_name_next;

    logic              res_valid_reg, res_valid_next;
    logic [ST_W-1:0]   status_reg, status_next;
    record_t           res_rec_reg, res_rec_next;
    logic              last_reg, last_next;

    wr_req_t           wr;
    rd_req_t           rd;
    record_t           rd_data;
    record_t           in_rec;
    logic              accept;
    logic              full;
    logic              empty;
    logic              scan_end;
    logic              hit;
    slot_t             step_slot;

    rdq_store u_store (
        .clk     (clk),
        .wr      (wr),
        .rd      (rd),
        .rd_data (rd_data)
    );

    assign accept   = start && (state_reg == S_IDLE);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign in_rec   = '{id: in_id, name: in_name, balance: in_balance};
    assign scan_end = ((CNT_W'(scan_k_reg) + CNT_W'(1)) == count_reg);
    assign hit      = (scan_op_reg == OP_FIND_ID) ? (rd_data.id == key_id_reg)
                                                  : (rd_data.name == key_name_reg);
    assign step_slot = (scan_op_reg == OP_WALK_BWD) ? slot_dec(scan_slot_reg)
                                                    : slot_inc(scan_slot_reg);

    always_comb
    begin
        state_next     = state_reg;
        front_next     = front_reg;
        count_next     = count_reg;
        scan_slot_next = scan_slot_reg;
        scan_k_next    = scan_k_reg;
        scan_op_next   = scan_op_reg;
        key_id_next    = key_id_reg;
        key_name_next  = key_name_reg;
        res_valid_next = 1'b0;
        status_next    = status_reg;
        res_rec_next   = res_rec_reg;
        last_next      = last_reg;
        wr             = '0;
        rd             = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_rec_next = '0;
                    last_next    = 1'b1;
                    unique case (op) inside
                        OP_ADD_FRONT, OP_ADD_BACK:
                        begin
                            res_valid_next = 1'b1;
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                wr.en       = 1'b1;
                                wr.data     = in_rec;
                                if (op == OP_ADD_FRONT)
                                begin
                                    wr.addr    = slot_dec(front_reg);
                                    front_next = slot_dec(front_reg);
                                end
                                else
                                begin
                                    wr.addr = slot_add(front_reg, count_reg[SLOT_W-1:0]);
                                end
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        OP_REMOVE:
                        begin
                            res_valid_next = 1'b1;
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                status_next = ST_OK;
                                front_next  = slot_inc(front_reg);
                                count_next  = count_reg - CNT_W'(1);
                            end
                        end
                        OP_WALK_FWD, OP_WALK_BWD, OP_FIND_ID, OP_FIND_NAME:
                        begin
                            if (empty)
                            begin
                                res_valid_next = 1'b1;
                                status_next    = ST_EMPTY;
                            end
                            else
                            begin
                                // Issue the first read now; its data arrives in the
                                // first scan cycle.
                                rd.en = 1'b1;
                                if (op == OP_WALK_BWD)
                                    rd.addr = slot_add(front_reg,
                                                       SLOT_W'(count_reg - CNT_W'(1)));
                                else
                                    rd.addr = front_reg;
                                scan_slot_next = rd.addr;
                                scan_k_next    = '0;
                                scan_op_next   = op;
                                key_id_next    = in_id;
                                key_name_next  = in_name;
                                state_next     = S_SCAN;
                            end
                        end
                        default:
                        begin
                            res_rec_next = res_rec_reg;
                            last_next    = last_reg;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if ((scan_op_reg == OP_WALK_FWD) || (scan_op_reg == OP_WALK_BWD))
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_OK;
                    res_rec_next   = rd_data;
                    last_next      = scan_end;
                end
                else if (hit)
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_OK;
                    res_rec_next   = rd_data;
                    last_next      = 1'b1;
                end
                else if (scan_end)
                begin
                    res_valid_next = 1'b1;
                    status_next    = ST_MISS;
                    res_rec_next   = '0;
                    last_next      = 1'b1;
                end

                if (scan_end || (res_valid_next && last_next))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    rd.en          = 1'b1;
                    rd.addr        = step_slot;
                    scan_slot_next = step_slot;
                    scan_k_next    = scan_k_reg + SLOT_W'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_slot_reg <= scan_slot_next;
        scan_k_reg    <= scan_k_next;
        scan_op_reg   <= scan_op_next;
        key_id_reg    <= key_id_next;
        key_name_reg  <= key_name_next;
        status_reg    <= status_next;
        res_rec_reg   <= res_rec_next;
        last_reg      <= last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign status       = status_reg;
    assign out_id       = res_rec_reg.id;
    assign out_name     = res_rec_reg.name;
    assign out_balance  = res_rec_reg.balance;
    assign last         = last_reg;

`ifndef ASSERT_OFF
    // The record count never exceeds the ring size.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("record count exceeds ring size");

    // A walk or search ends only together with its final result.
    a_scan_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> (result_valid && last))
        else $error("scan ended without a final result");

    // A non-ok status is always a single final result with cleared record fields.
    a_fail_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status != ST_OK)) |->
            (last && (out_id == '0) && (out_name == '0) && (out_balance == '0)))
        else $error("failure result carries record data");

    // An add into a full store leaves the store untouched.
    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && ((op == OP_ADD_FRONT) || (op == OP_ADD_BACK)) && full) |=>
            ($stable(count_reg) && $stable(front_reg) && (status == ST_FULL)))
        else $error("add into full store changed state");
`endif

endmodule

### src/rdq_store.sv
// ----------------------------------------------------------------------------
// rdq_store
// Record memory: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module rdq_store
    import rdq_pkg::*;
(
    input  logic    clk,
    input  wr_req_t wr,
    input  rd_req_t rd,
    output record_t rd_data
);

    record_t mem [DEPTH];
    record_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
